/* hw/rtl/word_sum_multiplicative_hash_unit_macros.svh */
// Assertion macros for the word sum multiplicative hash unit.
`ifndef WORD_SUM_MULTIPLICATIVE_HASH_UNIT_MACROS_SVH
`define WORD_SUM_MULTIPLICATIVE_HASH_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WSMH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WSMH_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define WSMH_ASSERT(label, prop, msg)
`define WSMH_ASSERT_NEVER(label, expr, msg)
`endif
`endif

/* hw/rtl/wsmh_pkg.sv */
// Shared types and constants of the word sum multiplicative hash unit.
`default_nettype none
package wsmh_pkg;
  localparam int HASH_BITS_DEFAULT = 30;
  localparam logic [31:0] HASH_MULT_LO = 32'd1410065337;
  localparam logic [7:0] SEPARATOR = 8'd32;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [31:0] term;
    logic        sep;
    logic        last;
  } wsmh_item_t;
endpackage
`default_nettype wire

/* hw/rtl/word_sum_multiplicative_hash_unit.sv */
// Throughput: one byte per cycle while full is low; the back hash multiplier is
// one stage, the front one is combinational, and the four-entry queue absorbs
// result-side stalls. Words pass the h_sum, prod and result registers in order.
// Reset: synchronous, active high; clears word state, total, queue and mode.
`default_nettype none
module word_sum_multiplicative_hash_unit
  import wsmh_pkg::*;
#(
  parameter int HASH_BITS = HASH_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte,
  input  wire logic        last_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      total_hash
);
  logic       weighted_mode;
  logic       q_push;
  logic       q_pop;
  logic       q_empty;
  wsmh_item_t wr_item;
  wsmh_item_t rd_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      weighted_mode <= cfg_wr_data;
    end
  end

  wsmh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .q_full        (full),
    .text_byte     (text_byte),
    .last_byte     (last_byte),
    .weighted_mode (weighted_mode),
    .q_push        (q_push),
    .q_item        (wr_item)
  );

  wsmh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (wr_item),
    .rd_en   (q_pop),
    .rd_item (rd_item),
    .q_full  (full),
    .q_empty (q_empty)
  );

  wsmh_back #(
    .HASH_BITS (HASH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_item     (rd_item),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .total_hash (total_hash)
  );
endmodule
`default_nettype wire

/* hw/rtl/wsmh_front.sv */
// Front part: takes bytes, tracks the position in the word and forms each byte's term.
`default_nettype none
module wsmh_front
  import wsmh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       q_full,
  input  wire logic [7:0] text_byte,
  input  wire logic       last_byte,
  input  wire logic       weighted_mode,
  output logic            q_push,
  output wsmh_item_t      q_item
);
  logic [31:0] position;
  logic [31:0] sval;
  logic        is_sep;

  assign is_sep = (text_byte == SEPARATOR);
  assign sval   = {{24{text_byte[7]}}, text_byte};
  assign q_push = push && !q_full;

  always_comb begin
    q_item.sep  = is_sep;
    q_item.last = last_byte;
    if (weighted_mode) begin
      q_item.term = sval * position;
    end else begin
      q_item.term = sval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 32'd0;
    end else if (q_push) begin
      if (is_sep || last_byte) begin
        position <= 32'd0;
      end else begin
        position <= position + 32'd1;
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/wsmh_queue.sv */
// Short queue between the front and back parts.
`default_nettype none
module wsmh_queue
  import wsmh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire wsmh_item_t wr_item,
  input  wire logic       rd_en,
  output wsmh_item_t      rd_item,
  output logic            q_full,
  output logic            q_empty
);
  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  wsmh_item_t          slots [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign q_full  = (count == CntW'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CntW'(1);
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/wsmh_back.sv */
// Back part: word sums, multiply-shift hashing, running total and result register.
`default_nettype none
`include "word_sum_multiplicative_hash_unit_macros.svh"
module wsmh_back
  import wsmh_pkg::*;
#(
  parameter int HASH_BITS = HASH_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  wire wsmh_item_t  q_item,
  output logic             q_pop,
  input  wire logic        pop,
  output logic             empty,
  output logic [63:0]      total_hash
);
  logic [31:0]          word_sum;
  logic [31:0]          sum_add;
  logic [31:0]          hash_in;
  logic                 ends;
  logic                 advance;
  logic                 h_valid;
  logic                 h_last;
  logic [31:0]          h_sum;
  logic                 p_valid;
  logic                 p_last;
  logic [31:0]          prod;
  logic [HASH_BITS-1:0] word_hash;
  logic [63:0]          total;
  logic [63:0]          total_add;
  logic                 out_valid;

  assign advance   = !(p_valid && p_last) || !out_valid || pop;
  assign q_pop     = advance && !q_empty;
  assign sum_add   = word_sum + q_item.term;
  assign ends      = q_item.sep || q_item.last;
  assign hash_in   = q_item.sep ? word_sum : sum_add;
  assign word_hash = prod[31 -: HASH_BITS];
  assign total_add = total + 64'(word_hash);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_sum  <= 32'd0;
      h_valid   <= 1'b0;
      p_valid   <= 1'b0;
      total     <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        h_valid <= q_pop && ends;
        p_valid <= h_valid;
        if (q_pop) begin
          word_sum <= ends ? 32'd0 : sum_add;
        end
        if (p_valid) begin
          total <= p_last ? 64'd0 : total_add;
        end
      end
      if (advance && p_valid && p_last) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      h_sum  <= hash_in;
      h_last <= q_item.last;
      prod   <= h_sum * HASH_MULT_LO;
      p_last <= h_last;
      if (p_valid && p_last) begin
        total_hash <= total_add;
      end
    end
  end

  `WSMH_ASSERT(a_result_waits, (p_valid && p_last && out_valid && !pop) |=> (p_valid && p_last), "Final hash lost while the result register was occupied.")
  `WSMH_ASSERT(a_total_clears, (advance && p_valid && p_last) |=> (total == 64'd0), "Running total not cleared after the result beat.")
  `WSMH_ASSERT(a_word_restarts, (q_pop && q_item.last) |=> (word_sum == 32'd0 && h_valid), "Word state not restarted after the final byte.")
endmodule
`default_nettype wire
